// ===== design/sound_file_player_bus_mapper_defines.svh =====
// ----------------------------------------------------------------------------
// Sound file player bus mapper assertion macros
// Shared macros for the concurrent checks on the block's ports.
// ----------------------------------------------------------------------------
`ifndef SOUND_FILE_PLAYER_BUS_MAPPER_DEFINES_SVH
`define SOUND_FILE_PLAYER_BUS_MAPPER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SFPBM_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SFPBM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/sfpbm_pkg.sv =====
// ----------------------------------------------------------------------------
// Sound file player bus mapper package
// Codes, controller types, interface structs and constant tables.
// ----------------------------------------------------------------------------
package sfpbm_pkg;

	localparam int WORK_RAM_DEPTH_DEF = 8192;
	localparam int SLOT_COUNT = 8;

	localparam logic [15:0] BANK_MASK  = 16'h5FF8;
	localparam logic [15:0] ADDR_INIT  = 16'h41FE;
	localparam logic [15:0] ADDR_FLAG  = 16'h41FF;
	localparam logic [15:0] ADDR_VECT  = 16'hFFFA;
	localparam logic [2:0]  RAM_REGION = 3'b011;
	localparam logic [7:0]  STUB_PAGE  = 8'h41;

	localparam logic [7:0] OFS_INIT_LO = 8'h01;
	localparam logic [7:0] OFS_INIT_HI = 8'h02;
	localparam logic [7:0] OFS_PLAY_LO = 8'h04;
	localparam logic [7:0] OFS_PLAY_HI = 8'h05;
	localparam logic [7:0] OFS_FLAG    = 8'hFF;

	localparam int BTN_LEFT  = 6;
	localparam int BTN_RIGHT = 7;

	localparam logic [2:0] CFG_BANK_COUNT    = 3'd0;
	localparam logic [2:0] CFG_FIRST_SONG    = 3'd1;
	localparam logic [2:0] CFG_SONG_TOTAL    = 3'd2;
	localparam logic [2:0] CFG_INIT_ADDR     = 3'd3;
	localparam logic [2:0] CFG_PLAY_ADDR     = 3'd4;
	localparam logic [2:0] CFG_BANK_ENABLE   = 3'd5;
	localparam logic [2:0] CFG_INITIAL_BANKS = 3'd6;

	typedef enum logic [1:0] {
		OP_READ     = 2'd0,
		OP_WRITE    = 2'd1,
		OP_POWER_ON = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		SRC_INTERNAL = 2'd0,
		SRC_ROM      = 2'd1,
		SRC_OPEN_BUS = 2'd2,
		SRC_NONE     = 2'd3
	} src_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACCESS,
		ST_CLEAR,
		ST_DIV_LOAD,
		ST_DIV_STEP,
		ST_STORE,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic access;
		logic clear_step;
		logic div_load;
		logic div_step;
		logic store;
		logic finish;
	} ctrl_cmd_t;

	typedef struct packed {
		logic is_init;
		logic is_power;
		logic bank_hit;
		logic bank_en;
		logic multi;
		logic div_last;
		logic slot_last;
		logic clear_last;
	} dp_status_t;

	function automatic logic [7:0] vector_byte(input logic [2:0] idx);
		logic [7:0] b;
		case (idx)
			3'd0: b = 8'h07;
			3'd1: b = 8'h41;
			3'd2: b = 8'h10;
			3'd3: b = 8'h41;
			3'd4: b = 8'h06;
			3'd5: b = 8'h41;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	function automatic logic [7:0] stub_byte(input logic [7:0] ofs);
		logic [7:0] b;
		case (ofs)
			8'h00: b = 8'h4C; 8'h03: b = 8'h4C; 8'h06: b = 8'h40; 8'h07: b = 8'h48;
			8'h08: b = 8'hAD; 8'h09: b = 8'h02; 8'h0A: b = 8'h20; 8'h0B: b = 8'h8D;
			8'h0C: b = 8'hFF; 8'h0D: b = 8'h41; 8'h0E: b = 8'h68; 8'h0F: b = 8'h40;
			8'h10: b = 8'h78; 8'h11: b = 8'hD8; 8'h12: b = 8'hA9; 8'h14: b = 8'h8D;
			8'h16: b = 8'h20; 8'h17: b = 8'h8D; 8'h18: b = 8'h01; 8'h19: b = 8'h20;
			8'h1A: b = 8'h2C; 8'h1B: b = 8'h02; 8'h1C: b = 8'h20; 8'h1D: b = 8'h2C;
			8'h1E: b = 8'h02; 8'h1F: b = 8'h20; 8'h20: b = 8'h10; 8'h21: b = 8'hFB;
			8'h22: b = 8'h2C; 8'h23: b = 8'h02; 8'h24: b = 8'h20; 8'h25: b = 8'h10;
			8'h26: b = 8'hFB; 8'h27: b = 8'hA9; 8'h28: b = 8'h80; 8'h29: b = 8'h8D;
			8'h2B: b = 8'h20; 8'h2C: b = 8'h8D; 8'h2D: b = 8'hFE; 8'h2E: b = 8'h41;
			8'h2F: b = 8'h20; 8'h31: b = 8'h41; 8'h32: b = 8'hA9; 8'h34: b = 8'h8D;
			8'h35: b = 8'hFF; 8'h36: b = 8'h41; 8'h37: b = 8'h2C; 8'h38: b = 8'hFF;
			8'h39: b = 8'h41; 8'h3A: b = 8'h10; 8'h3B: b = 8'hFB; 8'h3C: b = 8'hA9;
			8'h3E: b = 8'h8D; 8'h3F: b = 8'hFF; 8'h40: b = 8'h41; 8'h41: b = 8'h20;
			8'h42: b = 8'h03; 8'h43: b = 8'h41; 8'h44: b = 8'h2C; 8'h45: b = 8'hFF;
			8'h46: b = 8'h41; 8'h47: b = 8'h10; 8'h48: b = 8'hFB; 8'h49: b = 8'h30;
			8'h4A: b = 8'hF1;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

// ===== design/sfpbm_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sfpbm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// ===== design/sfpbm_ctrl.sv =====
// ----------------------------------------------------------------------------
// Bus mapper controller
// Sequences access, RAM clear, bank remainder steps and result delivery.
// ----------------------------------------------------------------------------
module sfpbm_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  sfpbm_pkg::dp_status_t  status,
	output sfpbm_pkg::ctrl_cmd_t   cmd,
	output logic                   busy
);

	import sfpbm_pkg::*;

	state_t state_q;
	state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_next = ST_ACCESS;
				end
			end
			ST_ACCESS: begin
				if (status.is_init) begin
					state_next = ST_CLEAR;
				end else if (status.is_power || status.bank_hit) begin
					state_next = ST_DIV_LOAD;
				end else begin
					state_next = ST_DONE;
				end
			end
			ST_CLEAR: begin
				if (status.clear_last) begin
					state_next = status.bank_en ? ST_DIV_LOAD : ST_DONE;
				end
			end
			ST_DIV_LOAD: begin
				state_next = ST_DIV_STEP;
			end
			ST_DIV_STEP: begin
				if (status.div_last) begin
					state_next = ST_STORE;
				end
			end
			ST_STORE: begin
				if (status.multi && !status.slot_last) begin
					state_next = ST_DIV_LOAD;
				end else begin
					state_next = ST_DONE;
				end
			end
			ST_DONE: begin
				state_next = ST_IDLE;
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			ST_ACCESS:   cmd.access     = 1'b1;
			ST_CLEAR:    cmd.clear_step = 1'b1;
			ST_DIV_LOAD: cmd.div_load   = 1'b1;
			ST_DIV_STEP: cmd.div_step   = 1'b1;
			ST_STORE:    cmd.store      = 1'b1;
			ST_DONE:     cmd.finish     = 1'b1;
			default: begin
				busy = 1'b1;
			end
		endcase
	end

endmodule

// ===== design/sfpbm_dp.sv =====
// ----------------------------------------------------------------------------
// Bus mapper datapath
// Item and configuration registers, bank slots, work RAM, bank remainder
// unit, song stepping and the result registers.
// ----------------------------------------------------------------------------
module sfpbm_dp #(
	parameter int RAM_DEPTH = sfpbm_pkg::WORK_RAM_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [1:0]            operation,
	input  logic [15:0]           address,
	input  logic [7:0]            write_data,
	input  logic [7:0]            buttons,
	input  logic                  cfg_we,
	input  logic [2:0]            cfg_index,
	input  logic [63:0]           cfg_data,
	input  sfpbm_pkg::ctrl_cmd_t  cmd,
	output sfpbm_pkg::dp_status_t status,
	output logic                  done,
	output logic [7:0]            read_data,
	output logic [1:0]            read_source,
	output logic [19:0]           rom_address,
	output logic                  init_request,
	output logic                  restart_request,
	output logic [7:0]            song_number
);

	import sfpbm_pkg::*;

	localparam int AW = $clog2(RAM_DEPTH);
	localparam logic [AW-1:0] LAST_IDX = AW'(RAM_DEPTH - 1);
	localparam logic [18:0] DEP1 = 19'(RAM_DEPTH);
	localparam logic [18:0] DEP2 = 19'(2 * RAM_DEPTH);
	localparam logic [18:0] DEP4 = 19'(4 * RAM_DEPTH);

	logic [1:0]  op_q;
	logic [15:0] addr_q;
	logic [7:0]  wdata_q;
	logic [7:0]  btn_q;

	logic [8:0]  rom_banks_q;
	logic [7:0]  first_song_q;
	logic [8:0]  song_total_q;
	logic [15:0] init_addr_q;
	logic [15:0] play_addr_q;
	logic        bank_en_q;
	logic [63:0] init_banks_q;

	logic [7:0]  bank_slots_q [SLOT_COUNT];
	logic [7:0]  song_q;
	logic [7:0]  flag_q;
	logic [7:0]  prev_btn_q;
	logic        restart_q;

	logic [2:0]    slot_q;
	logic [2:0]    step_q;
	logic [AW-1:0] clr_q;
	logic [7:0]    rem_q;
	logic [7:0]    div_sr_q;

	logic        done_q;
	logic [7:0]  read_data_q;
	logic [1:0]  read_source_q;
	logic [19:0] rom_address_q;
	logic        init_request_q;
	logic        restart_request_q;
	logic [7:0]  song_number_q;

	logic          is_read;
	logic          is_write;
	logic          is_power;
	logic          is_init;
	logic          is_flag;
	logic          ram_hit;
	logic          bank_hit;
	logic          multi;
	logic [18:0]   idx_red;
	logic [AW-1:0] ram_idx;
	logic [7:0]    ram_rd;
	logic          ram_we;
	logic [AW-1:0] ram_wa;
	logic [7:0]    ram_wd;
	logic [7:0]    song_limit;
	logic [7:0]    btn_rise;
	logic [8:0]    divisor;
	logic [8:0]    div_trial;
	logic [2:0]    slot_sel;
	logic [7:0]    dividend;
	logic [7:0]    rd_byte;
	logic [1:0]    rd_src;
	logic [19:0]   rom_addr;

	assign is_read  = (op_q == OP_READ);
	assign is_write = (op_q == OP_WRITE);
	assign is_power = (op_q == OP_POWER_ON);
	assign is_init  = is_write && (addr_q == ADDR_INIT);
	assign is_flag  = is_write && (addr_q == ADDR_FLAG);
	assign ram_hit  = (addr_q[15:13] == RAM_REGION);
	assign bank_hit = is_write && bank_en_q && ((addr_q & BANK_MASK) == BANK_MASK);
	assign multi    = is_init || is_power;

	// For a depth of at least 1024, the 13-bit RAM offset is below eight times the
	// depth, so three conditional subtractions reduce it modulo the depth.
	always_comb begin
		idx_red = {6'd0, addr_q[12:0]};
		if (idx_red >= DEP4) begin
			idx_red = idx_red - DEP4;
		end
		if (idx_red >= DEP2) begin
			idx_red = idx_red - DEP2;
		end
		if (idx_red >= DEP1) begin
			idx_red = idx_red - DEP1;
		end
		ram_idx = idx_red[AW-1:0];
	end

	assign ram_we = cmd.clear_step || (cmd.access && is_write && ram_hit);
	assign ram_wa = cmd.clear_step ? clr_q : ram_idx;
	assign ram_wd = cmd.clear_step ? 8'd0 : wdata_q;

	sfpbm_ram #(
		.WIDTH(8),
		.DEPTH(RAM_DEPTH)
	) u_ram (
		.clk    (clk),
		.wr_en  (ram_we),
		.wr_addr(ram_wa),
		.wr_data(ram_wd),
		.rd_addr(ram_idx),
		.rd_data(ram_rd)
	);

	assign song_limit = ((song_total_q == 9'd0) || (song_total_q > 9'd256)) ?
		8'hFF : 8'(song_total_q - 9'd1);
	assign btn_rise = btn_q & ~prev_btn_q;

	assign divisor   = (rom_banks_q == 9'd0) ? 9'd1 : rom_banks_q;
	assign div_trial = {rem_q, div_sr_q[7]};
	assign slot_sel  = multi ? slot_q : addr_q[2:0];

	always_comb begin
		if (is_power) begin
			dividend = {5'd0, slot_q};
		end else if (is_init) begin
			dividend = init_banks_q[{slot_q, 3'b000} +: 8];
		end else begin
			dividend = wdata_q;
		end
	end

	always_comb begin
		rd_byte  = 8'd0;
		rd_src   = SRC_NONE;
		rom_addr = 20'd0;
		if (is_read) begin
			rd_src = SRC_INTERNAL;
			if (addr_q[15]) begin
				if (addr_q >= ADDR_VECT) begin
					rd_byte = vector_byte(addr_q[2:0] - 3'd2);
				end else begin
					rd_src   = SRC_ROM;
					rom_addr = {bank_slots_q[addr_q[14:12]], addr_q[11:0]};
				end
			end else if (ram_hit) begin
				rd_byte = ram_rd;
			end else if (addr_q[15:8] == STUB_PAGE) begin
				case (addr_q[7:0])
					OFS_INIT_LO: rd_byte = init_addr_q[7:0];
					OFS_INIT_HI: rd_byte = init_addr_q[15:8];
					OFS_PLAY_LO: rd_byte = play_addr_q[7:0];
					OFS_PLAY_HI: rd_byte = play_addr_q[15:8];
					OFS_FLAG:    rd_byte = flag_q;
					default:     rd_byte = stub_byte(addr_q[7:0]);
				endcase
			end else begin
				rd_src = SRC_OPEN_BUS;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= operation;
			addr_q  <= address;
			wdata_q <= write_data;
			btn_q   <= buttons;
		end
		if (cmd.div_load) begin
			div_sr_q <= dividend;
		end else if (cmd.div_step) begin
			div_sr_q <= {div_sr_q[6:0], 1'b0};
		end
		if (cmd.finish) begin
			read_data_q       <= rd_byte;
			read_source_q     <= rd_src;
			rom_address_q     <= rom_addr;
			init_request_q    <= is_init;
			restart_request_q <= restart_q;
			song_number_q     <= song_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_banks_q  <= 9'd1;
			first_song_q <= 8'd1;
			song_total_q <= 9'd1;
			init_addr_q  <= 16'd0;
			play_addr_q  <= 16'd0;
			bank_en_q    <= 1'b0;
			init_banks_q <= 64'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BANK_COUNT:    rom_banks_q  <= cfg_data[8:0];
				CFG_FIRST_SONG:    first_song_q <= cfg_data[7:0];
				CFG_SONG_TOTAL:    song_total_q <= cfg_data[8:0];
				CFG_INIT_ADDR:     init_addr_q  <= cfg_data[15:0];
				CFG_PLAY_ADDR:     play_addr_q  <= cfg_data[15:0];
				CFG_BANK_ENABLE:   bank_en_q    <= cfg_data[0];
				CFG_INITIAL_BANKS: init_banks_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				bank_slots_q[i] <= 8'(i);
			end
			song_q     <= 8'd0;
			flag_q     <= 8'd0;
			prev_btn_q <= 8'd0;
			restart_q  <= 1'b0;
			slot_q     <= 3'd0;
			step_q     <= 3'd0;
			clr_q      <= '0;
			rem_q      <= 8'd0;
			done_q     <= 1'b0;
		end else begin
			done_q <= cmd.finish;
			if (cmd.load) begin
				restart_q <= 1'b0;
				slot_q    <= 3'd0;
				clr_q     <= '0;
			end
			if (cmd.access) begin
				if (is_power) begin
					song_q     <= first_song_q - 8'd1;
					flag_q     <= 8'd0;
					prev_btn_q <= 8'd0;
				end else if (is_flag) begin
					flag_q <= wdata_q;
					if (wdata_q != 8'd0) begin
						prev_btn_q <= btn_q;
						if (btn_rise[BTN_LEFT]) begin
							if (song_q != 8'd0) begin
								song_q    <= song_q - 8'd1;
								restart_q <= 1'b1;
							end
						end else if (btn_rise[BTN_RIGHT]) begin
							if (song_q < song_limit) begin
								song_q    <= song_q + 8'd1;
								restart_q <= 1'b1;
							end
						end
					end
				end
			end
			if (cmd.clear_step) begin
				clr_q <= clr_q + AW'(1);
			end
			if (cmd.div_load) begin
				rem_q  <= 8'd0;
				step_q <= 3'd0;
			end else if (cmd.div_step) begin
				rem_q  <= (div_trial >= divisor) ? 8'(div_trial - divisor) : div_trial[7:0];
				step_q <= step_q + 3'd1;
			end
			if (cmd.store) begin
				bank_slots_q[slot_sel] <= rem_q;
				slot_q <= slot_q + 3'd1;
			end
		end
	end

	assign status.is_init    = is_init;
	assign status.is_power   = is_power;
	assign status.bank_hit   = bank_hit;
	assign status.bank_en    = bank_en_q;
	assign status.multi      = multi;
	assign status.div_last   = (step_q == 3'd7);
	assign status.slot_last  = (slot_q == 3'(SLOT_COUNT - 1));
	assign status.clear_last = (clr_q == LAST_IDX);

	assign done            = done_q;
	assign read_data       = read_data_q;
	assign read_source     = read_source_q;
	assign rom_address     = rom_address_q;
	assign init_request    = init_request_q;
	assign restart_request = restart_request_q;
	assign song_number     = song_number_q;

endmodule

// ===== design/sound_file_player_bus_mapper.sv =====
// ----------------------------------------------------------------------------
// sound_file_player_bus_mapper: bus mapper for a sound-file player.
// Reads and plain writes pass access then done; bank writes add an 8-step remainder loop.
// Power-on: the remainder loop for each of the 8 slots; song init: a RAM clear sweep
// over every work RAM entry, then with banking on the remainder loop for all 8 slots.
// Asynchronous active-low reset clears control state; the receiver cannot stall.
// ----------------------------------------------------------------------------
module sound_file_player_bus_mapper #(
	parameter int WORK_RAM_DEPTH = sfpbm_pkg::WORK_RAM_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  operation,
	input  logic [15:0] address,
	input  logic [7:0]  write_data,
	input  logic [7:0]  buttons,
	output logic        done,
	output logic [7:0]  read_data,
	output logic [1:0]  read_source,
	output logic [19:0] rom_address,
	output logic        init_request,
	output logic        restart_request,
	output logic [7:0]  song_number,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	import sfpbm_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;

	assign cfg_ready = !busy;

	sfpbm_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.status(status),
		.cmd   (cmd),
		.busy  (busy)
	);

	sfpbm_dp #(
		.RAM_DEPTH(WORK_RAM_DEPTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.operation      (operation),
		.address        (address),
		.write_data     (write_data),
		.buttons        (buttons),
		.cfg_we         (cfg_valid && cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.cmd            (cmd),
		.status         (status),
		.done           (done),
		.read_data      (read_data),
		.read_source    (read_source),
		.rom_address    (rom_address),
		.init_request   (init_request),
		.restart_request(restart_request),
		.song_number    (song_number)
	);

endmodule

// ===== design/sfpbm_checker.sv =====
// ----------------------------------------------------------------------------
// Bus mapper port checker
// Concurrent checks on the top level's ports, bound to the top level.
// ----------------------------------------------------------------------------
`include "sound_file_player_bus_mapper_defines.svh"

module sfpbm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [7:0]  read_data,
	input logic [1:0]  read_source,
	input logic [19:0] rom_address,
	input logic        init_request,
	input logic        restart_request
);

	import sfpbm_pkg::*;

	`SFPBM_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted start did not raise busy")
	`SFPBM_ASSERT_NEXT(a_done_single, done, !done, "result strobe held for two cycles")
	`SFPBM_ASSERT_SAME(a_rom_zero, done && (read_source != SRC_ROM), rom_address == 20'd0, "rom_address nonzero without ROM source")
	`SFPBM_ASSERT_SAME(a_data_zero, done && (read_source != SRC_INTERNAL), read_data == 8'd0, "read_data nonzero without internal source")
	`SFPBM_ASSERT_SAME(a_req_write, done && (init_request || restart_request), read_source == SRC_NONE, "request raised on a read beat")

endmodule

bind sound_file_player_bus_mapper sfpbm_checker u_sfpbm_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.start          (start),
	.busy           (busy),
	.done           (done),
	.read_data      (read_data),
	.read_source    (read_source),
	.rom_address    (rom_address),
	.init_request   (init_request),
	.restart_request(restart_request)
);

// ===== dv/bus_access_checker.sv =====
// ----------------------------------------------------------------------------
// Bus access checker
// Watches the command, result and register channels of the sound file player
// bus mapper, predicts every result from its own copy of the mapper state and
// compares the results in order, field by field.
// ----------------------------------------------------------------------------
module bus_access_checker #(
	parameter int WORK_RAM_DEPTH = sfpbm_pkg::WORK_RAM_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [1:0]  operation,
	input  logic [15:0] address,
	input  logic [7:0]  write_data,
	input  logic [7:0]  buttons,
	input  logic        done,
	input  logic [7:0]  read_data,
	input  logic [1:0]  read_source,
	input  logic [19:0] rom_address,
	input  logic        init_request,
	input  logic        restart_request,
	input  logic [7:0]  song_number,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	output int          mismatch_count,
	output int          outstanding,
	output int          checked_count
);

	import sfpbm_pkg::*;

	localparam logic [15:0] VECTOR_BASE = 16'hFFFA;
	localparam logic [15:0] BANK_DECODE = 16'h5FF8;
	localparam logic [15:0] INIT_PORT   = 16'h41FE;
	localparam logic [15:0] FLAG_PORT   = 16'h41FF;
	localparam int          STUB_LENGTH = 75;

	localparam logic [0:5][7:0] VECTOR_IMAGE = {8'h07, 8'h41, 8'h10, 8'h41, 8'h06, 8'h41};

	localparam logic [0:STUB_LENGTH-1][7:0] STUB_IMAGE = {
		8'h4C, 8'h00, 8'h00, 8'h4C, 8'h00, 8'h00, 8'h40, 8'h48,
		8'hAD, 8'h02, 8'h20, 8'h8D, 8'hFF, 8'h41, 8'h68, 8'h40,
		8'h78, 8'hD8, 8'hA9, 8'h00, 8'h8D, 8'h00, 8'h20, 8'h8D,
		8'h01, 8'h20, 8'h2C, 8'h02, 8'h20, 8'h2C, 8'h02, 8'h20,
		8'h10, 8'hFB, 8'h2C, 8'h02, 8'h20, 8'h10, 8'hFB, 8'hA9,
		8'h80, 8'h8D, 8'h00, 8'h20, 8'h8D, 8'hFE, 8'h41, 8'h20,
		8'h00, 8'h41, 8'hA9, 8'h00, 8'h8D, 8'hFF, 8'h41, 8'h2C,
		8'hFF, 8'h41, 8'h10, 8'hFB, 8'hA9, 8'h00, 8'h8D, 8'hFF,
		8'h41, 8'h20, 8'h03, 8'h41, 8'h2C, 8'hFF, 8'h41, 8'h10,
		8'hFB, 8'h30, 8'hF1
	};

	typedef struct packed {
		logic [7:0]  data;
		src_t        source;
		logic [19:0] rom;
		logic        init_req;
		logic        restart;
		logic [7:0]  song;
	} access_result_t;

	logic [8:0]  rom_banks;
	logic [7:0]  first_song;
	logic [8:0]  song_total;
	logic [15:0] init_entry;
	logic [15:0] play_entry;
	logic        banking_on;
	logic [63:0] reload_banks;

	logic [7:0] bank_slot [SLOT_COUNT];
	logic [7:0] work_ram [WORK_RAM_DEPTH];
	logic [7:0] song_idx;
	logic [7:0] flag_byte;
	logic [7:0] held_buttons;

	access_result_t expected_results [$];
	access_result_t fresh;
	access_result_t oldest;

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (mismatch_count < 40) begin
			$display("checker: result %0d, %s: got 0x%0h, expected 0x%0h",
				checked_count, what, got, want);
		end
		mismatch_count++;
	endtask

	task automatic load_bank_slot(input int slot, input logic [7:0] bank);
		int count;
		count = (rom_banks == 0) ? 1 : int'(rom_banks);
		bank_slot[slot] = 8'(int'(bank) % count);
	endtask

	task automatic predict_bus_access(input logic [1:0] op, input logic [15:0] addr,
			input logic [7:0] wdata, input logic [7:0] btn, output access_result_t res);
		logic [7:0] rise;
		int ceiling;
		int ram_pos;
		res = '0;
		res.source = SRC_NONE;
		ram_pos = int'(addr & 16'h1FFF) % WORK_RAM_DEPTH;
		case (op)
			OP_READ: begin
				res.source = SRC_INTERNAL;
				if (addr[15]) begin
					if (addr >= VECTOR_BASE) begin
						res.data = VECTOR_IMAGE[addr - VECTOR_BASE];
					end else begin
						res.source = SRC_ROM;
						res.rom = {bank_slot[addr[14:12]], addr[11:0]};
					end
				end else if (addr[15:13] == 3'b011) begin
					res.data = work_ram[ram_pos];
				end else if (addr[15:8] == 8'h41) begin
					case (addr[7:0])
						8'h01: res.data = init_entry[7:0];
						8'h02: res.data = init_entry[15:8];
						8'h04: res.data = play_entry[7:0];
						8'h05: res.data = play_entry[15:8];
						8'hFF: res.data = flag_byte;
						default: begin
							res.data = (addr[7:0] < STUB_LENGTH) ? STUB_IMAGE[addr[7:0]] : 8'h00;
						end
					endcase
				end else begin
					res.source = SRC_OPEN_BUS;
				end
			end
			OP_WRITE: begin
				if (addr[15:13] == 3'b011) begin
					work_ram[ram_pos] = wdata;
				end
				if ((addr & BANK_DECODE) == BANK_DECODE && banking_on) begin
					load_bank_slot(int'(addr[2:0]), wdata);
				end
				if (addr == INIT_PORT) begin
					for (int i = 0; i < WORK_RAM_DEPTH; i++) work_ram[i] = 8'h00;
					if (banking_on) begin
						for (int i = 0; i < SLOT_COUNT; i++) load_bank_slot(i, reload_banks[8*i +: 8]);
					end
					res.init_req = 1'b1;
				end
				if (addr == FLAG_PORT) begin
					flag_byte = wdata;
					if (wdata != 8'h00) begin
						rise = btn & ~held_buttons;
						ceiling = (song_total == 0 || song_total > 256) ? 255 : int'(song_total) - 1;
						held_buttons = btn;
						if (rise[6]) begin
							if (song_idx != 0) begin
								song_idx--;
								res.restart = 1'b1;
							end
						end else if (rise[7]) begin
							if (int'(song_idx) < ceiling) begin
								song_idx++;
								res.restart = 1'b1;
							end
						end
					end
				end
			end
			OP_POWER_ON: begin
				for (int i = 0; i < SLOT_COUNT; i++) load_bank_slot(i, 8'(i));
				song_idx = first_song - 8'd1;
				flag_byte = 8'h00;
				held_buttons = 8'h00;
			end
			default: begin
			end
		endcase
		res.song = song_idx;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_banks = 9'd1;
			first_song = 8'd1;
			song_total = 9'd1;
			init_entry = '0;
			play_entry = '0;
			banking_on = 1'b0;
			reload_banks = '0;
			for (int i = 0; i < SLOT_COUNT; i++) bank_slot[i] = 8'(i);
			song_idx = '0;
			flag_byte = '0;
			held_buttons = '0;
			expected_results.delete();
			mismatch_count = 0;
			checked_count = 0;
			outstanding <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_BANK_COUNT:    rom_banks = cfg_data[8:0];
					CFG_FIRST_SONG:    first_song = cfg_data[7:0];
					CFG_SONG_TOTAL:    song_total = cfg_data[8:0];
					CFG_INIT_ADDR:     init_entry = cfg_data[15:0];
					CFG_PLAY_ADDR:     play_entry = cfg_data[15:0];
					CFG_BANK_ENABLE:   banking_on = cfg_data[0];
					CFG_INITIAL_BANKS: reload_banks = cfg_data;
					default: begin
					end
				endcase
			end
			if (start && !busy) begin
				predict_bus_access(operation, address, write_data, buttons, fresh);
				expected_results.push_back(fresh);
			end
			if (done) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result with no access pending", 32'd1, 32'd0);
				end else begin
					oldest = expected_results.pop_front();
					if (read_data != oldest.data)
						report_mismatch("read_data", read_data, oldest.data);
					if (read_source != oldest.source)
						report_mismatch("read_source", read_source, oldest.source);
					if (rom_address != oldest.rom)
						report_mismatch("rom_address", rom_address, oldest.rom);
					if (init_request != oldest.init_req)
						report_mismatch("init_request", init_request, oldest.init_req);
					if (restart_request != oldest.restart)
						report_mismatch("restart_request", restart_request, oldest.restart);
					if (song_number != oldest.song)
						report_mismatch("song_number", song_number, oldest.song);
				end
				checked_count++;
			end
			outstanding <= expected_results.size();
		end
	end

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// Sound file player bus mapper testbench
// Drives directed and random CPU bus accesses and register settings into the
// mapper, with random gaps between accesses, and lets the bus access checker
// judge every result beat.
// ----------------------------------------------------------------------------
module testbench;
	import sfpbm_pkg::*;

	localparam logic [1:0] OP_UNUSED   = 2'd3;
	localparam int         CYCLE_LIMIT = 2000000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  operation = '0;
	logic [15:0] address = '0;
	logic [7:0]  write_data = '0;
	logic [7:0]  buttons = '0;
	logic        done;
	logic [7:0]  read_data;
	logic [1:0]  read_source;
	logic [19:0] rom_address;
	logic        init_request;
	logic        restart_request;
	logic [7:0]  song_number;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [63:0] cfg_data = '0;

	int mismatch_count;
	int outstanding;
	int checked_count;
	int cycle_count = 0;
	int reads_sent = 0;
	int writes_sent = 0;
	int others_sent = 0;
	int sweeps_sent = 0;
	int settings_applied = 0;
	int inits_left = 0;
	bit idling_on = 1'b1;

	sound_file_player_bus_mapper i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operation(operation),
		.address(address),
		.write_data(write_data),
		.buttons(buttons),
		.done(done),
		.read_data(read_data),
		.read_source(read_source),
		.rom_address(rom_address),
		.init_request(init_request),
		.restart_request(restart_request),
		.song_number(song_number),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	bus_access_checker i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operation(operation),
		.address(address),
		.write_data(write_data),
		.buttons(buttons),
		.done(done),
		.read_data(read_data),
		.read_source(read_source),
		.rom_address(rom_address),
		.init_request(init_request),
		.restart_request(restart_request),
		.song_number(song_number),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.mismatch_count(mismatch_count),
		.outstanding(outstanding),
		.checked_count(checked_count)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic send_access(input logic [1:0] op, input logic [15:0] addr,
			input logic [7:0] wdata, input logic [7:0] btn);
		while (idling_on && $urandom_range(99) < 38) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		operation <= op;
		address <= addr;
		write_data <= wdata;
		buttons <= btn;
		@(posedge clk);
		while (busy) @(posedge clk);
		case (op)
			OP_READ: reads_sent++;
			OP_WRITE: writes_sent++;
			default: others_sent++;
		endcase
		if (op == OP_WRITE && addr == ADDR_INIT) sweeps_sent++;
	endtask

	task automatic wait_quiet();
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic apply_setting(input logic [8:0] bank_total, input logic [7:0] first,
			input logic [8:0] songs, input logic [15:0] init_at, input logic [15:0] play_at,
			input logic bank_en, input logic [63:0] banks);
		write_reg(CFG_BANK_COUNT, 64'(bank_total));
		write_reg(CFG_FIRST_SONG, 64'(first));
		write_reg(CFG_SONG_TOTAL, 64'(songs));
		write_reg(CFG_INIT_ADDR, 64'(init_at));
		write_reg(CFG_PLAY_ADDR, 64'(play_at));
		write_reg(CFG_BANK_ENABLE, 64'(bank_en));
		write_reg(CFG_INITIAL_BANKS, banks);
		cfg_valid <= 1'b0;
		@(posedge clk);
		settings_applied++;
		inits_left = 3;
	endtask

	task automatic random_access();
		int pick;
		int region;
		logic [1:0]  op;
		logic [15:0] addr;
		logic [7:0]  wdata;
		logic [7:0]  btn;
		pick = $urandom_range(99);
		region = $urandom_range(6);
		addr = 16'($urandom);
		wdata = 8'($urandom);
		btn = 8'($urandom);
		if (pick < 4) begin
			op = OP_POWER_ON;
		end else if (pick < 5) begin
			op = OP_UNUSED;
		end else if (pick < 50) begin
			op = OP_READ;
			case (region)
				0, 1: addr = addr | 16'h8000;
				2: addr = ADDR_VECT + 16'($urandom_range(5));
				3, 4: addr = {3'b011, addr[12:0]};
				5: addr = {8'h41, addr[7:0]};
				default: begin
				end
			endcase
		end else begin
			op = OP_WRITE;
			case (region)
				0: addr = {3'b011, addr[12:0]};
				1, 2: addr = addr | BANK_MASK;
				3, 4: begin
					addr = ADDR_FLAG;
					if ($urandom_range(7) != 0) wdata = 8'($urandom_range(1, 255));
					btn = {2'($urandom), btn[5:0]};
				end
				5: begin
					if (inits_left > 0 && $urandom_range(15) == 0) addr = ADDR_INIT;
					else addr = {3'b011, addr[12:0]};
				end
				default: begin
				end
			endcase
			if (addr == ADDR_INIT) begin
				if (inits_left > 0) inits_left--;
				else addr = ADDR_FLAG;
			end
		end
		send_access(op, addr, wdata, btn);
	endtask

	task automatic random_phase(input int count);
		for (int n = 0; n < count; n++) random_access();
		wait_quiet();
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_access(OP_WRITE, ADDR_INIT, 8'h00, 8'h00);
		send_access(OP_READ, 16'h8000, 8'h00, 8'h00);
		send_access(OP_READ, 16'hFFF9, 8'h00, 8'h00);
		send_access(OP_READ, 16'hFFFA, 8'h00, 8'h00);
		send_access(OP_READ, 16'hFFFF, 8'h00, 8'h00);
		send_access(OP_READ, 16'h6000, 8'h00, 8'h00);
		send_access(OP_WRITE, 16'h7FFF, 8'hFF, 8'h00);
		send_access(OP_READ, 16'h7FFF, 8'h00, 8'h00);
		send_access(OP_READ, 16'h4100, 8'h00, 8'h00);
		send_access(OP_READ, 16'h4102, 8'h00, 8'h00);
		send_access(OP_READ, 16'h4200, 8'h00, 8'h00);
		send_access(OP_READ, 16'h0000, 8'h00, 8'h00);
		send_access(OP_WRITE, 16'h5FF8, 8'h03, 8'h00);
		send_access(OP_READ, 16'h8000, 8'h00, 8'h00);
		send_access(OP_POWER_ON, 16'h0000, 8'h00, 8'h00);
		send_access(OP_UNUSED, 16'hFFFF, 8'hFF, 8'hFF);
		send_access(OP_WRITE, ADDR_FLAG, 8'h01, 8'h80);
		wait_quiet();

		apply_setting(9'd256, 8'd1, 9'd256, 16'hFFFF, 16'h0000, 1'b1, '1);
		send_access(OP_POWER_ON, 16'h0000, 8'h00, 8'h00);
		send_access(OP_WRITE, 16'h7FF8, 8'hAB, 8'h00);
		send_access(OP_READ, 16'h7FF8, 8'h00, 8'h00);
		send_access(OP_READ, 16'h8FFF, 8'h00, 8'h00);
		send_access(OP_WRITE, ADDR_FLAG, 8'hFF, 8'h80);
		send_access(OP_WRITE, ADDR_FLAG, 8'h01, 8'h00);
		send_access(OP_WRITE, ADDR_FLAG, 8'h01, 8'hC0);
		send_access(OP_READ, ADDR_FLAG, 8'h00, 8'h00);
		send_access(OP_WRITE, ADDR_FLAG, 8'h00, 8'h80);
		send_access(OP_WRITE, ADDR_INIT, 8'h00, 8'h00);
		send_access(OP_READ, 16'hF000, 8'h00, 8'h00);
		random_phase(150);

		idling_on = 1'b0;
		apply_setting(9'd1, 8'd255, 9'd1, 16'h0000, 16'hFFFF, 1'b1, {$urandom, $urandom});
		random_phase(150);
		idling_on = 1'b1;

		apply_setting(9'd0, 8'd0, 9'd0, 16'($urandom), 16'($urandom), 1'b1,
			{$urandom, $urandom});
		random_phase(100);

		for (int phase = 0; phase < 4; phase++) begin
			apply_setting(9'($urandom_range(1, 256)), 8'($urandom_range(1, 12)),
				9'($urandom_range(1, 12)), 16'($urandom), 16'($urandom),
				(phase == 0) ? 1'b0 : 1'($urandom), {$urandom, $urandom});
			random_phase(150);
		end

		repeat (20) @(posedge clk);
		$display("Covered %0d reads, %0d writes and %0d power-on or unused accesses,",
			reads_sent, writes_sent, others_sent);
		$display("%0d result beats checked over %0d register settings, %0d RAM clear sweeps.",
			checked_count, settings_applied, sweeps_sent);
		if (mismatch_count == 0 && outstanding == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
